### sv/tspg_pkg.sv
package tspg_pkg;

	localparam int unsigned RATE_W = 17;
	localparam int unsigned CFG_W = 32;
	localparam int unsigned CFG_ADDR_W = 3;

	localparam logic [CFG_ADDR_W-1:0] REG_MOVE_LENGTH = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_ENTRY_RATE = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_CRUISE_RATE = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_EXIT_RATE = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_ACCEL_STEP = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_STEP_SIZE = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_PROF,
		ST_DIV,
		ST_MUL,
		ST_BRK,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [31:0] move_length;
		logic [15:0] entry_rate;
		logic [15:0] cruise_rate;
		logic [15:0] end_rate;
		logic [15:0] accel_step;
		logic [15:0] step_size;
	} cfg_t;

	typedef struct packed {
		logic accept;
		logic load_step;
		logic prof;
		logic div_step;
		logic mul;
		logic brk;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic prof_div;
		logic div_last;
	} status_t;

endpackage

### sv/tspg_cfg_regs.sv
module tspg_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [tspg_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [tspg_pkg::CFG_W-1:0]          cfg_wdata,
	output tspg_pkg::cfg_t                      cfg
);

	tspg_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.move_length <= '0;
			cfg_q.entry_rate <= '0;
			cfg_q.cruise_rate <= '0;
			cfg_q.end_rate <= '0;
			cfg_q.accel_step <= '0;
			cfg_q.step_size <= 16'd1;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				tspg_pkg::REG_MOVE_LENGTH: cfg_q.move_length <= cfg_wdata;
				tspg_pkg::REG_ENTRY_RATE:  cfg_q.entry_rate <= cfg_wdata[15:0];
				tspg_pkg::REG_CRUISE_RATE: cfg_q.cruise_rate <= cfg_wdata[15:0];
				tspg_pkg::REG_EXIT_RATE:   cfg_q.end_rate <= cfg_wdata[15:0];
				tspg_pkg::REG_ACCEL_STEP:  cfg_q.accel_step <= cfg_wdata[15:0];
				tspg_pkg::REG_STEP_SIZE:   cfg_q.step_size <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### sv/tspg_ctrl.sv
module tspg_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  tspg_pkg::status_t   status,
	output tspg_pkg::cmd_t      cmd
);

	tspg_pkg::state_t state_q;
	tspg_pkg::state_t state_d;
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tspg_pkg::ST_IDLE: if (in_valid) state_d = tspg_pkg::ST_LOAD;
			tspg_pkg::ST_LOAD: state_d = tspg_pkg::ST_PROF;
			tspg_pkg::ST_PROF: begin
				state_d = status.prof_div ? tspg_pkg::ST_DIV : tspg_pkg::ST_OUT;
			end
			tspg_pkg::ST_DIV: if (status.div_last) state_d = tspg_pkg::ST_MUL;
			tspg_pkg::ST_MUL: state_d = tspg_pkg::ST_BRK;
			tspg_pkg::ST_BRK: state_d = tspg_pkg::ST_OUT;
			tspg_pkg::ST_OUT: if (out_free) state_d = tspg_pkg::ST_IDLE;
			default: state_d = tspg_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			tspg_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.accept = in_valid;
			end
			tspg_pkg::ST_LOAD: cmd.load_step = 1'b1;
			tspg_pkg::ST_PROF: cmd.prof = 1'b1;
			tspg_pkg::ST_DIV:  cmd.div_step = 1'b1;
			tspg_pkg::ST_MUL:  cmd.mul = 1'b1;
			tspg_pkg::ST_BRK:  cmd.brk = 1'b1;
			tspg_pkg::ST_OUT:  cmd.out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tspg_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result register overwritten while pending");

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == tspg_pkg::ST_LOAD))
		else $error("accepted tick not processed");

	a_div_to_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tspg_pkg::ST_DIV && status.div_last) |=> (state_q == tspg_pkg::ST_MUL))
		else $error("divider end not followed by multiply");

endmodule

### sv/tspg_datapath.sv
module tspg_datapath #(
	parameter int unsigned DISTANCE_BITS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tspg_pkg::cfg_t                 cfg,
	input  tspg_pkg::cmd_t                 cmd,
	output tspg_pkg::status_t              status,
	input  logic                           start_req,
	output logic                           step_pulse,
	output logic                           busy_res,
	output logic                           move_done,
	output logic [tspg_pkg::RATE_W-1:0]    rate_now
);

	localparam int unsigned DW = DISTANCE_BITS;
	localparam int unsigned DW1 = DW + 1;
	localparam int unsigned CW = (DW1 > 32) ? DW1 : 32;
	localparam int unsigned PW = (DW > 33) ? DW : 33;
	localparam int unsigned RW = tspg_pkg::RATE_W;

	logic          start_q;
	logic          active_q;
	logic [RW-1:0] rate_q;
	logic [DW-1:0] dd_q;
	logic [DW-1:0] brk_q;
	logic [DW-1:0] acc_q;
	logic          pulse_q;
	logic          done_q;
	logic [16:0]   rem_q;
	logic [15:0]   quo_q;
	logic [3:0]    div_cnt_q;
	logic [32:0]   prod_q;

	logic          out_pulse_q;
	logic          out_busy_q;
	logic          out_done_q;
	logic [RW-1:0] out_rate_q;

	logic          load;
	logic [DW-1:0] acc_eff;
	logic          step_ge;
	logic [CW-1:0] cmp_sum;
	logic          run_ph;
	logic          brake_ph;
	logic [DW:0]   dd_sum;
	logic [DW:0]   acc_sum;
	logic [DW-1:0] dd_sat;
	logic [DW-1:0] acc_sat;
	logic [RW:0]   rate_inc;
	logic [RW-1:0] rate_run;
	logic [RW-1:0] rate_dec;
	logic          accel_zero;
	logic [16:0]   rem_sh;
	logic          rem_ge;
	logic [PW-1:0] prod_ext;
	logic [PW-1:0] dmax_ext;
	logic [DW-1:0] brk_sat;

	assign load = !active_q && start_q;
	assign acc_eff = load ? '0 : acc_q;
	assign step_ge = acc_eff >= DW'(cfg.step_size);

	assign cmp_sum = CW'(dd_q) + CW'(brk_q);
	assign run_ph = cmp_sum < CW'(cfg.move_length);
	assign brake_ph = rate_q > RW'(cfg.end_rate);

	assign dd_sum = {1'b0, dd_q} + DW1'(rate_q);
	assign acc_sum = {1'b0, acc_q} + DW1'(rate_q);
	assign dd_sat = dd_sum[DW] ? {DW{1'b1}} : dd_sum[DW-1:0];
	assign acc_sat = acc_sum[DW] ? {DW{1'b1}} : acc_sum[DW-1:0];

	assign rate_inc = {1'b0, rate_q} + (RW+1)'(cfg.accel_step);
	assign rate_run = (rate_q < RW'(cfg.cruise_rate)) ? rate_inc[RW-1:0] : RW'(cfg.cruise_rate);
	assign rate_dec = (rate_q > RW'(cfg.accel_step)) ? rate_q - RW'(cfg.accel_step) : '0;
	assign accel_zero = cfg.accel_step == '0;

	assign rem_sh = {rem_q[15:0], quo_q[15]};
	assign rem_ge = rem_sh >= {1'b0, cfg.accel_step};

	assign prod_ext = PW'(prod_q);
	assign dmax_ext = PW'({DW{1'b1}});
	assign brk_sat = (prod_ext > dmax_ext) ? {DW{1'b1}} : prod_ext[DW-1:0];

	assign status.prof_div = active_q && run_ph && !accel_zero;
	assign status.div_last = div_cnt_q == 4'd15;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b0;
			active_q <= 1'b0;
			rate_q <= '0;
			dd_q <= '0;
			brk_q <= '0;
			acc_q <= '0;
			pulse_q <= 1'b0;
			done_q <= 1'b0;
			div_cnt_q <= '0;
		end else begin
			if (cmd.accept) begin
				start_q <= start_req;
			end
			if (cmd.load_step) begin
				done_q <= 1'b0;
				pulse_q <= (active_q || load) && step_ge;
				if (load) begin
					active_q <= 1'b1;
					rate_q <= RW'(cfg.entry_rate);
					dd_q <= '0;
					brk_q <= '0;
				end
				if ((active_q || load) && step_ge) begin
					acc_q <= acc_eff - DW'(cfg.step_size);
				end else if (load) begin
					acc_q <= '0;
				end
			end
			if (cmd.prof && active_q) begin
				priority if (run_ph) begin
					dd_q <= dd_sat;
					acc_q <= acc_sat;
					rate_q <= rate_run;
					if (accel_zero) begin
						brk_q <= '0;
					end
					div_cnt_q <= '0;
				end else if (brake_ph) begin
					dd_q <= dd_sat;
					acc_q <= acc_sat;
					rate_q <= rate_dec;
				end else begin
					active_q <= 1'b0;
					rate_q <= '0;
					dd_q <= '0;
					brk_q <= '0;
					acc_q <= '0;
					done_q <= 1'b1;
				end
			end
			if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + 4'd1;
			end
			if (cmd.brk) begin
				brk_q <= brk_sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.prof) begin
			rem_q <= '0;
			quo_q <= rate_run[16:1];
		end else if (cmd.div_step) begin
			rem_q <= rem_ge ? rem_sh - {1'b0, cfg.accel_step} : rem_sh;
			quo_q <= {quo_q[14:0], rem_ge};
		end
		if (cmd.mul) begin
			prod_q <= 33'(quo_q) * 33'(rate_q);
		end
		if (cmd.out_load) begin
			out_pulse_q <= pulse_q;
			out_busy_q <= active_q;
			out_done_q <= done_q;
			out_rate_q <= rate_q;
		end
	end

	assign step_pulse = out_pulse_q;
	assign busy_res = out_busy_q;
	assign move_done = out_done_q;
	assign rate_now = out_rate_q;

	a_idle_rate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> (rate_q == '0))
		else $error("idle with nonzero rate");

	a_div_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.prof && status.prof_div) |=> (div_cnt_q == '0))
		else $error("divider not restarted");

endmodule

### sv/trapezoid_step_pulse_generator.sv
// channel  direction  handshake              payload
// in       sink       in_valid / in_ready    start_req
// out      source     out_valid / out_ready  step_pulse, busy_res, move_done, rate_now
// cfg      sink       cfg_we                 cfg_addr, cfg_wdata
//
// A tick goes from transfer through the load, profile and output states when no braking distance
// is needed; in the run phase with nonzero acceleration it also passes the 16-step restoring
// divider for the braking distance, then a multiply state and a braking-distance update state.
// Reset clears the move state and loads step_size with 1, the others with 0.
// A tick is taken while a result still waits; its result then holds until the
// pending one is transferred.
module trapezoid_step_pulse_generator #(
	parameter int unsigned DISTANCE_BITS = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               start_req,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               step_pulse,
	output logic                               busy_res,
	output logic                               move_done,
	output logic [tspg_pkg::RATE_W-1:0]        rate_now,
	input  logic                               cfg_we,
	input  logic [tspg_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [tspg_pkg::CFG_W-1:0]         cfg_wdata
);

	tspg_pkg::cfg_t    cfg;
	tspg_pkg::cmd_t    cmd;
	tspg_pkg::status_t status;

	tspg_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	tspg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	tspg_datapath #(
		.DISTANCE_BITS (DISTANCE_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.cmd        (cmd),
		.status     (status),
		.start_req  (start_req),
		.step_pulse (step_pulse),
		.busy_res   (busy_res),
		.move_done  (move_done),
		.rate_now   (rate_now)
	);

endmodule

### tb/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SETTLE_CYCLES = 30;
	localparam int RANDOM_PROFILES = 36;
	localparam int TICKS_PER_PROFILE = 50;
	localparam int COAST_TICKS = 200;

	typedef struct packed {
		logic                        step_pulse;
		logic                        busy;
		logic                        done;
		logic [tspg_pkg::RATE_W-1:0] rate;
	} tick_result_t;

	class stepper_scoreboard;
		logic [31:0]                 move_length;
		logic [15:0]                 entry_rate;
		logic [15:0]                 cruise_rate;
		logic [15:0]                 end_rate;
		logic [15:0]                 accel_step;
		logic [15:0]                 step_size;
		bit                          moving;
		logic [tspg_pkg::RATE_W-1:0] rate;
		logic [31:0]                 travelled;
		logic [31:0]                 brake;
		logic [31:0]                 accum;
		tick_result_t                outcomes[$];
		int                          errors;

		function void park();
			moving = 1'b0;
			rate = '0;
			travelled = '0;
			brake = '0;
			accum = '0;
		endfunction

		function void clear();
			move_length = '0;
			entry_rate = '0;
			cruise_rate = '0;
			end_rate = '0;
			accel_step = '0;
			step_size = 16'd1;
			errors = 0;
			park();
		endfunction

		function void write_reg(logic [tspg_pkg::CFG_ADDR_W-1:0] addr,
				logic [tspg_pkg::CFG_W-1:0] data);
			case (addr)
				tspg_pkg::REG_MOVE_LENGTH: move_length = data;
				tspg_pkg::REG_ENTRY_RATE:  entry_rate = data[15:0];
				tspg_pkg::REG_CRUISE_RATE: cruise_rate = data[15:0];
				tspg_pkg::REG_EXIT_RATE:   end_rate = data[15:0];
				tspg_pkg::REG_ACCEL_STEP:  accel_step = data[15:0];
				tspg_pkg::REG_STEP_SIZE:   step_size = data[15:0];
				default: ;
			endcase
		endfunction

		function logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
			logic [32:0] s;
			s = {1'b0, a} + {1'b0, b};
			return s[32] ? '1 : s[31:0];
		endfunction

		function void note_tick(bit start);
			tick_result_t r;
			logic [63:0]  prod;
			r = '0;
			if (!moving && start) begin
				park();
				moving = 1'b1;
				rate = tspg_pkg::RATE_W'(entry_rate);
			end
			if (moving) begin
				if (accum >= 32'(step_size)) begin
					r.step_pulse = 1'b1;
					accum = accum - 32'(step_size);
				end
				if (33'(travelled) + 33'(brake) < 33'(move_length)) begin
					travelled = sat_add(travelled, 32'(rate));
					accum = sat_add(accum, 32'(rate));
					if (rate < tspg_pkg::RATE_W'(cruise_rate))
						rate = rate + tspg_pkg::RATE_W'(accel_step);
					else
						rate = tspg_pkg::RATE_W'(cruise_rate);
					if (accel_step == 16'd0) begin
						brake = '0;
					end else begin
						prod = 64'((rate >> 1) / accel_step) * 64'(rate);
						brake = prod > 64'hFFFF_FFFF ? '1 : prod[31:0];
					end
				end else if (rate > tspg_pkg::RATE_W'(end_rate)) begin
					travelled = sat_add(travelled, 32'(rate));
					accum = sat_add(accum, 32'(rate));
					rate = rate > tspg_pkg::RATE_W'(accel_step) ?
						rate - tspg_pkg::RATE_W'(accel_step) : '0;
				end else begin
					park();
					r.done = 1'b1;
				end
			end
			r.busy = moving;
			r.rate = rate;
			outcomes.push_back(r);
		endfunction

		function void compare(string field, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
				errors++;
			end
		endfunction

		function void check_result(tick_result_t got);
			tick_result_t want;
			if (outcomes.size() == 0) begin
				$display("%0t: result transferred with none outstanding", $time);
				errors++;
			end else begin
				want = outcomes.pop_front();
				compare("step_pulse", 32'(want.step_pulse), 32'(got.step_pulse));
				compare("busy_res", 32'(want.busy), 32'(got.busy));
				compare("move_done", 32'(want.done), 32'(got.done));
				compare("rate_now", 32'(want.rate), 32'(got.rate));
			end
		endfunction
	endclass

	logic                            clk;
	logic                            arst_n;
	logic                            in_valid;
	logic                            in_ready;
	logic                            start_req;
	logic                            out_valid;
	logic                            out_ready;
	logic                            step_pulse;
	logic                            busy_res;
	logic                            move_done;
	logic [tspg_pkg::RATE_W-1:0]     rate_now;
	logic                            cfg_we;
	logic [tspg_pkg::CFG_ADDR_W-1:0] cfg_addr;
	logic [tspg_pkg::CFG_W-1:0]      cfg_wdata;

	stepper_scoreboard sb = new();
	bit steady = 1'b0;

	trapezoid_step_pulse_generator dut (.*);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	initial begin
		#30_000_000;
		$display("simulation failed");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result('{step_pulse, busy_res, move_done, rate_now});
	end

	initial begin
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 3);
			if (stall != 0) begin
				@(negedge clk) out_ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk) out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic load_reg(logic [tspg_pkg::CFG_ADDR_W-1:0] addr,
			logic [tspg_pkg::CFG_W-1:0] data);
		// fill bits above the register width with noise
		if (addr != tspg_pkg::REG_MOVE_LENGTH)
			data[31:16] = 16'($urandom());
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= data;
		sb.write_reg(addr, data);
		@(negedge clk) cfg_we <= 1'b0;
	endtask

	task automatic load_profile(logic [31:0] len, logic [15:0] entry, logic [15:0] cruise,
			logic [15:0] exit_r, logic [15:0] accel, logic [15:0] step);
		load_reg(tspg_pkg::REG_MOVE_LENGTH, len);
		load_reg(tspg_pkg::REG_ENTRY_RATE, 32'(entry));
		load_reg(tspg_pkg::REG_CRUISE_RATE, 32'(cruise));
		load_reg(tspg_pkg::REG_EXIT_RATE, 32'(exit_r));
		load_reg(tspg_pkg::REG_ACCEL_STEP, 32'(accel));
		load_reg(tspg_pkg::REG_STEP_SIZE, 32'(step));
	endtask

	task automatic send_tick(bit start);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			@(negedge clk) in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		start_req <= start;
		do @(posedge clk); while (!in_ready);
		sb.note_tick(start);
	endtask

	// hold input off until every outstanding result has been transferred
	task automatic settle();
		@(negedge clk) in_valid <= 1'b0;
		while (sb.outcomes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] pick(logic [31:0] typical, logic [31:0] top);
		case ($urandom_range(0, 9))
			0: return '0;
			1: return top;
			default: return $urandom_range(0, typical);
		endcase
	endfunction

	initial begin
		int waited;
		sb.clear();
		arst_n = 1'b0;
		in_valid = 1'b0;
		start_req = 1'b0;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// idle tick, then a zero-length move that ends on its first tick
		send_tick(1'b0);
		send_tick(1'b1);
		settle();

		load_profile(32'd600, 16'd0, 16'd60, 16'd4, 16'd9, 16'd16);
		repeat (16) send_tick(1'b1);
		settle();

		// zero acceleration with zero step size: braking never ends
		load_profile(32'd50, 16'd20, 16'd20, 16'd0, 16'd0, 16'd0);
		repeat (6) send_tick(1'b1);
		settle();
		load_reg(tspg_pkg::REG_EXIT_RATE, 32'hFFFF);
		load_reg(tspg_pkg::REG_STEP_SIZE + 3'd1, $urandom());
		load_reg(tspg_pkg::REG_STEP_SIZE + 3'd2, $urandom());
		send_tick(1'b0);
		send_tick(1'b1);
		settle();

		for (int p = 0; p < RANDOM_PROFILES; p++) begin
			steady = ($urandom_range(0, 3) == 0);
			load_profile(pick(32'd4000, 32'hFFFF_FFFF), 16'(pick(32'd300, 32'hFFFF)),
				16'(pick(32'd300, 32'hFFFF)), 16'(pick(32'd60, 32'hFFFF)),
				16'(pick(32'd40, 32'hFFFF)), 16'(pick(32'd400, 32'hFFFF)));
			repeat (TICKS_PER_PROFILE) send_tick($urandom_range(0, 9) < 6);
			settle();
		end

		// overshoot past cruise, then coast with no deceleration
		steady = 1'b1;
		load_profile(32'd1, 16'd65534, 16'd65535, 16'd0, 16'd65535, 16'd0);
		send_tick(1'b1);
		settle();
		load_reg(tspg_pkg::REG_ACCEL_STEP, 32'd0);
		repeat (COAST_TICKS) send_tick(1'b1);
		settle();
		load_reg(tspg_pkg::REG_ACCEL_STEP, 32'hFFFF);
		repeat (4) send_tick(1'b0);
		settle();
		steady = 1'b0;

		waited = 0;
		while (sb.outcomes.size() != 0 && waited < 10000) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.outcomes.size() == 0) begin
			$display("simulation ok");
		end else begin
			if (sb.outcomes.size() != 0)
				$display("%0t: %0d results never transferred", $time, sb.outcomes.size());
			$display("simulation failed");
		end
		$finish;
	end
endmodule
